// File: rtl/assert_macros.svh
// assertion macros for the rtl files, used by the round-to-integral core
// no dependencies; include once per file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/f64rti_pkg.sv
// types and constants for the binary64 round-to-integral core
// no dependencies
`default_nettype none

package f64rti_pkg;

  // rounding mode codes as carried on the opcode field
  typedef enum logic [2:0] {
    RND_NEAR_EVEN = 3'd0,
    RND_ZERO      = 3'd1,
    RND_DOWN      = 3'd2,
    RND_UP        = 3'd3,
    RND_NEAR_AWAY = 3'd4
  } rnd_mode_e;

  localparam int unsigned FracW  = 52;
  localparam int unsigned ExpW   = 11;
  localparam int unsigned ShiftW = 6;

  localparam logic [ExpW-1:0] ExpAllOnes = 11'h7FF;
  localparam logic [ExpW-1:0] ExpBias    = 11'd1023;
  localparam logic [ExpW-1:0] ExpHalf    = 11'd1022;
  localparam logic [ExpW-1:0] ExpIntegral = 11'd1075;

  localparam logic [63:0] FracField = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [62:0] OneBits   = 63'h3FF0_0000_0000_0000;

endpackage

`default_nettype wire

// File: rtl/fp64_round_to_integral_core.sv
// binary64 round-to-integral core, two register stages
// depends on f64rti_pkg and assert_macros.svh
`default_nettype none

// Usage
//   input channel: in_valid_i with value_bits_i (binary64 operand) and
//   opcode_i (rounding mode); a beat is taken at a rising edge where
//   in_valid_i is high and in_stall_o is low
//   output channel: out_valid_o with result_bits_o; a beat leaves at an
//   edge where out_valid_o is high and out_stall_i is low
//   path: a taken beat passes through two register stages, the operand
//   register and then the result register, which it enters once free
//   throughput: one beat per cycle unless the receiver stalls; the rounding
//   logic sits in one pass between the operand and result registers
//   stall: when the receiver stalls, the result register holds its beat;
//   the operand register still takes a beat if it is empty, and
//   in_stall_o rises only once both registers are full
//   reset: rst_ni clears both valid flags asynchronously; no beats are
//   lost afterwards and no stale data is shown
//   NaN and infinity pass through untouched, zeros keep their sign
//   opcodes above nearest-away round to nearest even
module fp64_round_to_integral_core
  import f64rti_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] value_bits_i,
  input  wire logic [2:0]  opcode_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_bits_o
);
`include "assert_macros.svh"

  // operand stage
  logic        s1_valid_q;
  logic [63:0] s1_value_q;
  logic [2:0]  s1_op_q;

  // result stage
  logic        out_valid_q;
  logic [63:0] result_q;

  logic out_free;
  logic in_take;

  // rounding datapath
  rnd_mode_e          mode;
  logic               sgn;
  logic [ExpW-1:0]    bexp;
  logic [ExpW-1:0]    unb;
  logic [ShiftW-1:0]  sh;
  logic [63:0]        fmask;
  logic [63:0]        trunc;
  logic [63:0]        ulp;
  logic [63:0]        half;
  logic               half_bit;
  logic               below_set;
  logic               odd;
  logic               step;
  logic               to_one;
  logic [63:0]        rounded;

  // result register can take a beat when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o   = out_valid_q;
  assign result_bits_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_value_q <= value_bits_i;
      s1_op_q    <= opcode_i;
    end
    if (out_free && s1_valid_q) begin
      result_q <= rounded;
    end
  end

  // unused codes fall back to nearest even
  always_comb begin
    case (s1_op_q)
      RND_ZERO:      mode = RND_ZERO;
      RND_DOWN:      mode = RND_DOWN;
      RND_UP:        mode = RND_UP;
      RND_NEAR_AWAY: mode = RND_NEAR_AWAY;
      default:       mode = RND_NEAR_EVEN;
    endcase
  end

  assign sgn  = s1_value_q[63];
  assign bexp = s1_value_q[62:52];
  assign unb  = bexp - ExpBias;
  // only meaningful for exponents inside the fractional range
  assign sh   = unb[ShiftW-1:0];

  assign fmask     = FracField >> sh;
  assign trunc     = s1_value_q & ~fmask;
  assign ulp       = 64'd1 << (6'(FracW) - sh);
  assign half      = ulp >> 1;
  assign half_bit  = (s1_value_q & half) != 64'd0;
  assign below_set = (s1_value_q & (half - 64'd1)) != 64'd0;
  // at unbiased exponent zero the integer lsb is the hidden one
  assign odd       = (sh == '0) ? 1'b1 : ((trunc & ulp) != 64'd0);

  always_comb begin
    case (mode)
      RND_ZERO: begin
        step   = 1'b0;
        to_one = 1'b0;
      end
      RND_DOWN: begin
        step   = sgn;
        to_one = sgn;
      end
      RND_UP: begin
        step   = !sgn;
        to_one = !sgn;
      end
      RND_NEAR_AWAY: begin
        step   = half_bit;
        to_one = (bexp == ExpHalf);
      end
      default: begin
        step   = half_bit && (below_set || odd);
        to_one = (bexp == ExpHalf) && (s1_value_q[FracW-1:0] != '0);
      end
    endcase
  end

  always_comb begin
    if (bexp == ExpAllOnes) begin
      // nan and infinity unchanged
      rounded = s1_value_q;
    end else if (bexp < ExpBias) begin
      if (s1_value_q[62:0] == 63'd0) begin
        rounded = s1_value_q;
      end else begin
        rounded = to_one ? {sgn, OneBits} : {sgn, 63'd0};
      end
    end else if (bexp >= ExpIntegral) begin
      rounded = s1_value_q;
    end else if ((s1_value_q & fmask) == 64'd0) begin
      rounded = s1_value_q;
    end else begin
      // carry out of the fraction runs into the exponent
      rounded = step ? (trunc + ulp) : trunc;
    end
  end

  // a stall upstream only when both stages are full and the sink holds
  `ASSERT_CLK(a_stall_cause, clk_i, rst_ni,
              in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
  // an accepted beat always lands in the operand stage
  `ASSERT_CLK(a_take_lands, clk_i, rst_ni, in_take |=> s1_valid_q)
  // nan and infinity reach the result register bit for bit
  `ASSERT_CLK(a_special_pass, clk_i, rst_ni,
              (s1_valid_q && out_free && (bexp == ExpAllOnes))
                |=> (result_q == $past(s1_value_q)))
  // a finite operand never turns into nan or infinity
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni,
                s1_valid_q && (bexp != ExpAllOnes) && (rounded[62:52] == ExpAllOnes))

endmodule

`default_nettype wire

// File: tb/fp64_round_to_integral_core_test.sv
// testbench for fp64_round_to_integral_core: directed and random binary64 operands
// depends on f64rti_pkg and the core; own predictor, results checked beat by beat
`timescale 1ns / 100ps

module fp64_round_to_integral_core_test;
  import f64rti_pkg::*;

  // spare opcodes, all of them behave as nearest-even
  localparam logic [2:0] OpSpareLo  = 3'd5;
  localparam logic [2:0] OpSpareMid = 3'd6;
  localparam logic [2:0] OpSpareHi  = 3'd7;

  // one rounding in flight: the operand, its mode and the result it must give
  typedef struct {
    logic [63:0] operand;
    logic [2:0]  opcode;
    logic [63:0] rounded;
  } rounding_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] value_bits_i;
  logic [2:0]  opcode_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_bits_o;

  // roundings accepted by the core whose result has not come out yet
  rounding_t   pending_roundings[$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  fp64_round_to_integral_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_bits_i (value_bits_i),
    .opcode_i     (opcode_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_bits_o(result_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous time limit: a hung run ends with a mismatch
  initial begin
    #2_000_000;
    $display("fp64_round_to_integral_core: mismatch");
    $finish;
  end

  // expected integral value of one operand under one rounding mode
  function automatic logic [63:0] round_to_integral(input logic [63:0] v, input logic [2:0] op);
    rnd_mode_e       mode;
    logic            neg;
    logic [ExpW-1:0] bexp;
    int unsigned     shift;
    logic [63:0]     fmask;
    logic [63:0]     trunc;
    logic [63:0]     ulp;
    logic [63:0]     half;
    logic [63:0]     below;
    logic            odd;
    logic            step;
    // anything past nearest-away falls back to nearest-even
    mode = (op > RND_NEAR_AWAY) ? RND_NEAR_EVEN : rnd_mode_e'(op);
    neg  = v[63];
    bexp = v[62:52];
    // nan and infinity pass through with payload
    if (bexp == ExpAllOnes) return v;
    // magnitude below one, subnormals included: signed zero or signed one
    if (bexp < ExpBias) begin
      if (v[62:0] == '0) return v;
      case (mode)
        RND_ZERO:      step = 1'b0;
        RND_DOWN:      step = neg;
        RND_UP:        step = !neg;
        // only the [0.5, 1) binade can reach one when rounding to nearest
        RND_NEAR_AWAY: step = (bexp == ExpHalf);
        // exactly one half is a tie and goes to the even zero
        default:       step = (bexp == ExpHalf) && (v[51:0] != '0);
      endcase
      return step ? {neg, OneBits} : {neg, 63'd0};
    end
    // no fraction bits left below the binary point
    if (bexp >= ExpIntegral) return v;
    shift = bexp - ExpBias;
    fmask = FracField >> shift;
    if ((v & fmask) == '0) return v;
    trunc = v & ~fmask;
    ulp   = 64'd1 << (FracW - shift);
    half  = ulp >> 1;
    below = half - 64'd1;
    // with exponent zero the integer lsb is the hidden one, always odd
    odd   = (shift == 0) ? 1'b1 : trunc[FracW - shift];
    case (mode)
      RND_ZERO:      step = 1'b0;
      RND_DOWN:      step = neg;
      RND_UP:        step = !neg;
      RND_NEAR_AWAY: step = ((v & half) != '0);
      default:       step = ((v & half) != '0) && (((v & below) != '0) || odd);
    endcase
    // adding one ulp to the combined field lets the carry run into the exponent
    return step ? trunc + ulp : trunc;
  endfunction

  // random operand, biased toward the binades where rounding actually happens
  function automatic logic [63:0] pick_operand();
    logic [63:0]     v;
    logic [ExpW-1:0] e;
    logic [51:0]     f;
    logic [63:0]     low_mask;
    int unsigned     k;
    v = {$urandom, $urandom};
    e = v[62:52];
    f = v[51:0];
    k = $urandom_range(0, FracW - 1);
    // fraction bits below the integer lsb for exponent k
    low_mask = (64'd1 << (FracW - k)) - 64'd1;
    case ($urandom_range(0, 11))
      0: ;
      1, 2, 3: e = ExpW'(ExpBias + k);
      // exact tie: half bit set, nothing below it
      4, 5: begin
        e = ExpW'(ExpBias + k);
        f = (f & ~low_mask[51:0]) | (52'd1 << (FracW - 1 - k));
      end
      // already integral
      6: begin
        e = ExpW'(ExpBias + k);
        f = f & ~low_mask[51:0];
      end
      // all-ones fraction, any step up carries into the exponent
      7: begin
        e = ExpW'(ExpBias + k);
        f = '1;
      end
      // below one, often in the [0.5, 1) binade, sometimes exactly one half
      8, 9: begin
        e = $urandom_range(0, 1) ? ExpHalf : ExpW'($urandom_range(0, ExpHalf));
        if ($urandom_range(0, 3) == 0) f = '0;
      end
      // around the point where no fraction bits remain
      10: e = ExpW'($urandom_range(ExpIntegral - 1, ExpIntegral + 1));
      // nan, infinity or zero
      default: begin
        if ($urandom_range(0, 1)) begin
          e = ExpAllOnes;
          if ($urandom_range(0, 2) == 0) f = '0;
        end else begin
          e = '0;
          f = '0;
        end
      end
    endcase
    return {v[63], e, f};
  endfunction

  // offers one beat at the falling edge, holds it until the core takes it
  task automatic send_operand(input logic [63:0] v, input logic [2:0] op);
    rounding_t entry;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_bits_i <= v;
    opcode_i     <= op;
    do @(posedge clk_i); while (in_stall_o);
    entry.operand = v;
    entry.opcode  = op;
    entry.rounded = round_to_integral(v, op);
    pending_roundings.push_back(entry);
    @(negedge clk_i);
  endtask

  // zeros, infinities, nans and subnormals
  task automatic test_special_operands();
    send_operand(64'h0000_0000_0000_0000, RND_NEAR_EVEN);
    send_operand(64'h8000_0000_0000_0000, RND_UP);
    send_operand(64'h7FF0_0000_0000_0000, RND_ZERO);
    send_operand(64'hFFF0_0000_0000_0000, RND_DOWN);
    // quiet nan with payload, signalling nan with sign set
    send_operand(64'h7FF8_0000_0000_1234, RND_NEAR_AWAY);
    send_operand(64'hFFF0_0000_0000_0001, OpSpareLo);
    // smallest subnormal goes up to one, largest negative one down to minus one
    send_operand(64'h0000_0000_0000_0001, RND_UP);
    send_operand(64'h800F_FFFF_FFFF_FFFF, RND_DOWN);
  endtask

  // magnitudes below one, with both ties at one half
  task automatic test_below_one();
    send_operand(64'h3FE0_0000_0000_0000, RND_NEAR_EVEN);
    send_operand(64'h3FE0_0000_0000_0000, RND_NEAR_AWAY);
    send_operand(64'hBFE0_0000_0000_0000, OpSpareMid);
    send_operand(64'h3FE8_0000_0000_0000, RND_NEAR_EVEN);
    send_operand(64'hBFE8_0000_0000_0000, RND_ZERO);
  endtask

  // ties, steps in each direction, carries and operands that are already integral
  task automatic test_rounding_steps();
    // 1.5 to 2.0 carries into the exponent
    send_operand(64'h3FF8_0000_0000_0000, RND_NEAR_EVEN);
    send_operand(64'h3FF8_0000_0000_0000, RND_NEAR_AWAY);
    send_operand(64'h4004_0000_0000_0000, RND_NEAR_EVEN);
    send_operand(64'hC004_0000_0000_0000, RND_NEAR_AWAY);
    // 2^52 - 0.5: odd integer part, the tie steps up to 2^52
    send_operand(64'h432F_FFFF_FFFF_FFFF, RND_NEAR_EVEN);
    send_operand(64'h4330_0000_0000_0000, OpSpareHi);
    send_operand(64'h7FEF_FFFF_FFFF_FFFF, RND_DOWN);
    send_operand(64'h4008_0000_0000_0000, RND_UP);
    send_operand(64'hBFF4_0000_0000_0000, RND_DOWN);
    send_operand(64'h3FF4_0000_0000_0000, RND_UP);
    send_operand(64'hBFFC_0000_0000_0000, OpSpareLo);
    // one plus one ulp: hidden bit is the integer lsb
    send_operand(64'h3FF0_0000_0000_0001, RND_UP);
  endtask

  task automatic test_random_operands(input int unsigned count);
    repeat (count) send_operand(pick_operand(), 3'($urandom_range(0, 7)));
  endtask

  // receiver: random stall, changed at the falling edge only
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // result checker: each beat taken against the oldest pending rounding
  always @(posedge clk_i) begin
    rounding_t entry;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roundings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h", result_bits_o);
      end else begin
        entry = pending_roundings.pop_front();
        if (result_bits_o !== entry.rounded) begin
          mismatches++;
          if (mismatches <= 10)
            $display("operand %h opcode %0d: expected %h, got %h",
                     entry.operand, entry.opcode, entry.rounded, result_bits_o);
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_bits_i  = '0;
    opcode_i      = RND_NEAR_EVEN;
    mismatches    = 0;
    send_idle_pct = 26;
    recv_idle_pct = 56;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // first phase: sender idles lightly, receiver stalls often
    test_special_operands();
    test_below_one();
    test_rounding_steps();
    test_random_operands(350);

    // second phase: roles swapped
    send_idle_pct = 56;
    recv_idle_pct = 26;
    test_random_operands(350);

    // third phase: back to back at full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_operands(350);

    in_valid_i <= 1'b0;
    while (pending_roundings.size() != 0) @(posedge clk_i);
    // wait past the two register stages to catch stray beats
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_roundings.size() == 0)
      $display("fp64_round_to_integral_core: match");
    else
      $display("fp64_round_to_integral_core: mismatch");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/f64rti_pkg.sv
rtl/fp64_round_to_integral_core.sv
tb/fp64_round_to_integral_core_test.sv
